// ===== rtl/rfpd_pkg.sv =====
package rfpd_pkg;

  // Longest accepted payload length (decoded byte 0); shortest is fixed at 8
  localparam int unsigned MAX_PAYLOAD_LEN = 9;
  localparam int unsigned MIN_PAYLOAD_LEN = 8;

  // Reflected CRC-16 polynomial, zero init
  localparam logic [15:0] CRC16_GEN = 16'h8408;

  // Configuration reset values
  localparam logic [7:0] SYNC_RESET   = 8'h18;
  localparam logic [3:0] MARKER_RESET = 4'hA;
  localparam logic [7:0] JUMP_RESET   = 8'h54;

  // Offset table rows for the two descrambled payload bytes (payload index - 1)
  localparam logic [2:0] ROW_COMMAND  = 3'd3;
  localparam logic [2:0] ROW_ARGUMENT = 3'd4;

  localparam logic [7:0] OFFSET_TAB [8][4] = '{
    '{8'h45, 8'h1F, 8'h14, 8'h5C},
    '{8'h2B, 8'hC9, 8'hE3, 8'h11},
    '{8'hEE, 8'hDE, 8'h0B, 8'hAA},
    '{8'hAF, 8'h03, 8'h1D, 8'hF3},
    '{8'h1A, 8'hE2, 8'hF0, 8'hD1},
    '{8'h04, 8'hD8, 8'h71, 8'h42},
    '{8'hAF, 8'h04, 8'hDD, 8'h07},
    '{8'hE1, 8'h93, 8'hB8, 8'hE4}
  };

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SYNC   = 3'd1,
    ST_BAD_MARKER = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_CRC_ERR    = 3'd4,
    ST_REPEAT_ID  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [3:0] marker_nibble;
    logic [7:0] jump_start;
  } cfg_t;

  typedef struct packed {
    logic       packet_start;
    logic [7:0] raw_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  command;
    logic [7:0]  argument;
    logic [31:0] packet_id;
  } result_t;

  function automatic logic [3:0] nib_rev(input logic [3:0] n);
    return {n[0], n[1], n[2], n[3]};
  endfunction

  // Decoded byte from the low nibble of the previous raw byte and the high nibble of this one
  function automatic logic [7:0] decode_byte(input logic [7:0] prev, input logic [7:0] raw);
    return {nib_rev(raw[7:4]), nib_rev(prev[3:0])};
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) c = (c >> 1) ^ CRC16_GEN;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [7:0] make_xkey(input logic [7:0] k);
    logic       sh;
    logic [2:0] x;
    logic [3:0] msn;
    logic [3:0] lsn;
    sh  = (k[3:0] >= 4'd4);
    x   = k[6:4] + {2'b00, sh} + 3'd6;
    msn = (4'd4 + {1'b0, x}) ^ 4'd1;
    lsn = (k[3:0] + 4'd4) ^ 4'd2;
    return {msn, lsn};
  endfunction

  function automatic logic [7:0] descramble(input logic [7:0] b, input logic [2:0] row,
                                            input logic [7:0] k, input logic [7:0] js);
    logic [7:0] off;
    logic       jump;
    off  = OFFSET_TAB[row][k[1:0]];
    jump = (js != 8'd0) && (k >= js) && ({1'b0, k} <= ({1'b0, js} + 9'h080));
    if (jump) off = off + 8'h80;
    return (b - off) ^ make_xkey(k);
  endfunction

endpackage

// ===== rtl/rfpd_in_reg.sv =====
module rfpd_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rfpd_pkg::item_t in_item,
  input  logic            take,
  output logic            item_valid,
  output rfpd_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  rfpd_pkg::item_t item_r;

  // Accept when empty or when the held word leaves this cycle
  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) valid_nxt = 1'b1;
    else if (take) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_item;
  end

endmodule

// ===== rtl/rfpd_core.sv =====
module rfpd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  rfpd_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  rfpd_pkg::item_t   item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output rfpd_pkg::result_t result
);

  localparam logic [7:0] MaxLen = 8'(rfpd_pkg::MAX_PAYLOAD_LEN);
  localparam logic [7:0] MinLen = 8'(rfpd_pkg::MIN_PAYLOAD_LEN);
  localparam logic [5:0] MaxPos = 6'(rfpd_pkg::MAX_PAYLOAD_LEN + 4);

  // Control state
  logic        active_r, active_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] last_id_r, last_id_nxt;

  // Packet payload state
  logic [7:0]  prev_r, prev_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  key_r, key_nxt;
  logic [31:0] id_r, id_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  arg_r, arg_nxt;
  rfpd_pkg::result_t res_r, res_nxt;

  logic              emit;
  rfpd_pkg::status_t st;
  logic [7:0]        d;
  logic [5:0]        j;
  logic [5:0]        len_eff;
  logic              go;

  assign take      = !out_valid_r || out_ready;
  assign go        = take && item_valid;
  assign out_valid = out_valid_r;
  assign result    = res_r;

  assign d       = rfpd_pkg::decode_byte(prev_r, item.raw_byte);
  assign j       = pos_r - 6'd2;
  assign len_eff = (j == 6'd0) ? d[5:0] : len_r;

  // Decode one word and update packet state
  always_comb begin
    active_nxt  = active_r;
    pos_nxt     = pos_r;
    last_id_nxt = last_id_r;
    prev_nxt    = prev_r;
    len_nxt     = len_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;
    key_nxt     = key_r;
    id_nxt      = id_r;
    cmd_nxt     = cmd_r;
    arg_nxt     = arg_r;
    emit        = 1'b0;
    st          = rfpd_pkg::ST_OK;
    res_nxt     = '{status: rfpd_pkg::ST_OK, command: 8'd0, argument: 8'd0, packet_id: 32'd0};

    if (go) begin
      if (item.packet_start) begin
        active_nxt = 1'b1;
        pos_nxt    = 6'd1;
        prev_nxt   = item.raw_byte;
        len_nxt    = 6'd0;
        crc_nxt    = 16'd0;
        crc_lo_nxt = 8'd0;
        key_nxt    = 8'd0;
        id_nxt     = 32'd0;
        cmd_nxt    = 8'd0;
        arg_nxt    = 8'd0;
        if (item.raw_byte != cfg.sync_value) begin
          emit = 1'b1;
          st   = rfpd_pkg::ST_BAD_SYNC;
        end
      end else if (active_r) begin
        prev_nxt = item.raw_byte;
        if (pos_r == 6'd1) begin
          // Marker nibble check
          if (item.raw_byte[7:4] != cfg.marker_nibble) begin
            emit = 1'b1;
            st   = rfpd_pkg::ST_BAD_MARKER;
          end else begin
            pos_nxt = 6'd2;
          end
        end else if (j == 6'd0 && (d < MinLen || d > MaxLen)) begin
          emit = 1'b1;
          st   = rfpd_pkg::ST_BAD_LENGTH;
        end else begin
          if (j == 6'd0) len_nxt = d[5:0];
          if (j <= len_eff) crc_nxt = rfpd_pkg::crc_byte(crc_r, d);

          // Collect key, id bytes and descrambled command fields
          unique case (j)
            6'd1: begin
              key_nxt       = d;
              id_nxt[31:28] = d[7:4];
            end
            6'd2: id_nxt[23:16] = d;
            6'd3: id_nxt[15:8]  = d;
            6'd5: cmd_nxt = rfpd_pkg::descramble(d, rfpd_pkg::ROW_COMMAND, key_r,
                                                 cfg.jump_start);
            6'd6: arg_nxt = rfpd_pkg::descramble(d, rfpd_pkg::ROW_ARGUMENT, key_r,
                                                 cfg.jump_start);
            6'd7: id_nxt[7:0] = d;
            default: ;
          endcase

          if (j == len_eff + 6'd1) crc_lo_nxt = d;

          // Trailing CRC high byte closes the packet
          if (j == len_eff + 6'd2) begin
            emit              = 1'b1;
            res_nxt.packet_id = id_r;
            if ({d, crc_lo_r} != crc_r) begin
              st = rfpd_pkg::ST_CRC_ERR;
            end else if (id_r == last_id_r) begin
              st = rfpd_pkg::ST_REPEAT_ID;
            end else begin
              st               = rfpd_pkg::ST_OK;
              last_id_nxt      = id_r;
              res_nxt.command  = cmd_r;
              res_nxt.argument = arg_r;
            end
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
      end

      if (emit) begin
        active_nxt = 1'b0;
        pos_nxt    = 6'd0;
      end
    end
    res_nxt.status = st;
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= 6'd0;
      out_valid_r <= 1'b0;
      last_id_r   <= 32'd0;
    end else begin
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      last_id_r   <= last_id_nxt;
    end
  end

  // Hold packet payload; every field but the result is rewritten at packet start
  always_ff @(posedge clk) begin
    prev_r   <= prev_nxt;
    len_r    <= len_nxt;
    crc_r    <= crc_nxt;
    crc_lo_r <= crc_lo_nxt;
    key_r    <= key_nxt;
    id_r     <= id_nxt;
    cmd_r    <= cmd_nxt;
    arg_r    <= arg_nxt;
    if (emit) res_r <= res_nxt;
  end

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> pos_r == 6'd0)
    else $error("position not cleared while idle");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pos_r >= 6'd1 && pos_r <= MaxPos))
    else $error("position outside packet span");

  a_early_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status == rfpd_pkg::ST_BAD_SYNC ||
                    res_r.status == rfpd_pkg::ST_BAD_MARKER ||
                    res_r.status == rfpd_pkg::ST_BAD_LENGTH)
    |-> (res_r.packet_id == 32'd0 && res_r.command == 8'd0 && res_r.argument == 8'd0))
    else $error("early error result carries data");

  a_ok_updates_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && st == rfpd_pkg::ST_OK) |=> (last_id_r == res_r.packet_id))
    else $error("last reported id not updated on good packet");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("result produced while result register is full");

endmodule

// ===== rtl/rf_remote_packet_decoder.sv =====
// A word accepted into the input register is decoded out of it and loads its result, if any,
// into the result register.
// Throughput: one raw word per cycle while out_tready is high; a result left waiting stalls
// decode, the input register takes one more word, then in_tready drops.
// Reset (rst_n, synchronous, active low): no packet active, last reported id zero,
// configuration back to sync 0x18, marker 0xA, jump start 0x54.
module rf_remote_packet_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] raw_byte
  input  logic        in_tuser,   // [0] packet_start
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [2:0] status, [10:3] command, [18:11] argument,
                                  // [50:19] packet_id, [55:51] zero
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [1:0] {
    CFG_SYNC   = 2'd0,
    CFG_MARKER = 2'd1,
    CFG_JUMP   = 2'd2
  } cfg_idx_t;

  rfpd_pkg::cfg_t    cfg_r, cfg_nxt;
  rfpd_pkg::item_t   in_item;
  rfpd_pkg::item_t   item;
  rfpd_pkg::result_t result;
  logic              item_valid;
  logic              take;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC:   cfg_nxt.sync_value    = cfg_data;
        CFG_MARKER: cfg_nxt.marker_nibble = cfg_data[3:0];
        CFG_JUMP:   cfg_nxt.jump_start    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{sync_value:    rfpd_pkg::SYNC_RESET,
                 marker_nibble: rfpd_pkg::MARKER_RESET,
                 jump_start:    rfpd_pkg::JUMP_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item = '{packet_start: in_tuser, raw_byte: in_tdata};

  rfpd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rfpd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result     (result)
  );

  // Pack result word, first field lowest
  assign out_tdata = {5'd0, result.packet_id, result.argument, result.command,
                      result.status};

endmodule
